// File: design/vscm_pkg.sv
// Shared types and constants for the version string caret match block.
package vscm_pkg;

  localparam int FIELD_BITS = 32;
  localparam int REQ_BITS   = 32;
  localparam int OUT_BITS   = 32;
  localparam int CMP_BITS   = (FIELD_BITS > REQ_BITS) ? FIELD_BITS : REQ_BITS;
  localparam int PROD_BITS  = FIELD_BITS + 4;
  localparam int NUM_FIELDS = 3;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [REQ_BITS-1:0]   req_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [1:0]            fidx_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2e;

  localparam fidx_t FIDX_MAJOR = 2'd0;
  localparam fidx_t FIDX_MINOR = 2'd1;
  localparam fidx_t FIDX_PATCH = 2'd2;

  typedef enum logic [1:0] {
    CFG_REQ_EXACT = 2'd0,
    CFG_REQ_MAJOR = 2'd1,
    CFG_REQ_MINOR = 2'd2,
    CFG_REQ_PATCH = 2'd3
  } cfg_idx_t;

endpackage

// File: design/version_string_caret_match.sv
// Top level: streaming version string parser with exact or caret requirement check.
// A result enters the output register when its last item leaves the input register.
// Throughput: one item per cycle unless a last item waits on a stalled result; the field
// update (multiply by ten plus digit) and the three-field requirement compare sit between the two registers.
// Reset (rst_n low, synchronous) clears the requirement registers, parse state and valids.
module version_string_caret_match import vscm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  req_t       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_has_char,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_well_formed,
  output logic       out_allowed,
  output logic [OUT_BITS-1:0] out_major,
  output logic [OUT_BITS-1:0] out_minor,
  output logic [OUT_BITS-1:0] out_patch
);

  // requirement registers
  logic req_exact_r;
  req_t req_major_r, req_minor_r, req_patch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_exact_r <= 1'b0;
      req_major_r <= '0;
      req_minor_r <= '0;
      req_patch_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REQ_EXACT: req_exact_r <= cfg_wdata[0];
        CFG_REQ_MAJOR: req_major_r <= cfg_wdata;
        CFG_REQ_MINOR: req_minor_r <= cfg_wdata;
        CFG_REQ_PATCH: req_patch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_r;
  logic       s1_has_char_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       out_free;
  logic       s1_fire;
  logic       s1_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign s1_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_has_char_r <= in_has_char;
      s1_ch_r       <= in_ch;
      s1_last_r     <= in_last;
    end
  end

  // parse state
  field_t fv_r [NUM_FIELDS];
  fidx_t  fidx_r;
  logic   seen_r;
  logic   failed_r;

  field_t fv_nxt [NUM_FIELDS];
  fidx_t  fidx_nxt;
  logic   seen_nxt;
  logic   failed_nxt;
  field_t cur_val;
  prod_t  prod;
  logic [3:0] digit;

  always_comb begin
    fv_nxt     = fv_r;
    fidx_nxt   = fidx_r;
    seen_nxt   = seen_r;
    failed_nxt = failed_r;
    digit      = s1_ch_r[3:0] - CH_ZERO[3:0];
    cur_val    = fv_r[fidx_r];
    prod       = (PROD_BITS'(cur_val) << 3) + (PROD_BITS'(cur_val) << 1) + PROD_BITS'(digit);
    if (s1_has_char_r && !failed_r) begin
      if (s1_ch_r inside {[CH_ZERO:CH_NINE]}) begin
        if (|prod[PROD_BITS-1:FIELD_BITS]) begin
          failed_nxt = 1'b1;
        end else begin
          fv_nxt[fidx_r] = prod[FIELD_BITS-1:0];
          seen_nxt       = 1'b1;
        end
      end else if (s1_ch_r == CH_DOT) begin
        if (!seen_r || fidx_r == FIDX_PATCH) begin
          failed_nxt = 1'b1;
        end else begin
          fidx_nxt = fidx_r + 2'd1;
          seen_nxt = 1'b0;
        end
      end else begin
        failed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) fv_r[i] <= '0;
      fidx_r   <= FIDX_MAJOR;
      seen_r   <= 1'b0;
      failed_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        for (int i = 0; i < NUM_FIELDS; i++) fv_r[i] <= '0;
        fidx_r   <= FIDX_MAJOR;
        seen_r   <= 1'b0;
        failed_r <= 1'b0;
      end else begin
        fv_r     <= fv_nxt;
        fidx_r   <= fidx_nxt;
        seen_r   <= seen_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  // requirement check on the final values
  logic ok;
  cmp_t ma, mi, pa, rma, rmi, rpa;
  logic lower, bound, allow;

  always_comb begin
    ok  = !failed_nxt && seen_nxt;
    ma  = CMP_BITS'(fv_nxt[FIDX_MAJOR]);
    mi  = CMP_BITS'(fv_nxt[FIDX_MINOR]);
    pa  = CMP_BITS'(fv_nxt[FIDX_PATCH]);
    rma = CMP_BITS'(req_major_r);
    rmi = CMP_BITS'(req_minor_r);
    rpa = CMP_BITS'(req_patch_r);
    if (ma != rma)      lower = ma < rma;
    else if (mi != rmi) lower = mi < rmi;
    else                lower = pa < rpa;
    // leftmost non-zero required field sets the upper limit
    if (rma != '0)      bound = ma == rma;
    else if (rmi != '0) bound = (ma == '0) && (mi == rmi);
    else if (rpa != '0) bound = (ma == '0) && (mi == '0) && (pa == rpa);
    else                bound = ma == '0;
    if (req_exact_r) allow = (ma == rma) && (mi == rmi) && (pa == rpa);
    else             allow = !lower && bound;
  end

  // result register
  logic                out_valid_r;
  logic                out_wf_r, out_allowed_r;
  logic [OUT_BITS-1:0] out_major_r, out_minor_r, out_patch_r;
  logic                res_load;

  assign res_load = s1_fire && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_wf_r      <= ok;
      out_allowed_r <= ok && allow;
      out_major_r   <= ok ? ma[OUT_BITS-1:0] : '0;
      out_minor_r   <= ok ? mi[OUT_BITS-1:0] : '0;
      out_patch_r   <= ok ? pa[OUT_BITS-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_well_formed = out_wf_r;
  assign out_allowed     = out_allowed_r;
  assign out_major       = out_major_r;
  assign out_minor       = out_minor_r;
  assign out_patch       = out_patch_r;

  // checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (fidx_r == FIDX_MAJOR) && !seen_r && !failed_r)
    else $error("parse state not cleared after last item");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    fidx_r != 2'd3)
    else $error("field index out of range");

  a_allowed_wf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_allowed_r || out_wf_r))
    else $error("allowed without well formed");

  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wf_r) |->
      (out_major_r == '0) && (out_minor_r == '0) && (out_patch_r == '0))
    else $error("malformed result carries non-zero numbers");

endmodule

// File: test/vscm_checker.sv
// Checker for the version string caret match block: predicts each verdict and compares it.
module vscm_checker import vscm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  req_t                cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_has_char,
  input  logic [7:0]          in_ch,
  input  logic                in_last,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_well_formed,
  input  logic                out_allowed,
  input  logic [OUT_BITS-1:0] out_major,
  input  logic [OUT_BITS-1:0] out_minor,
  input  logic [OUT_BITS-1:0] out_patch,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                well_formed;
    logic                allowed;
    logic [OUT_BITS-1:0] major;
    logic [OUT_BITS-1:0] minor;
    logic [OUT_BITS-1:0] patch;
  } verdict_t;

  localparam longint unsigned FIELD_MAX = (64'd1 << FIELD_BITS) - 64'd1;

  logic            req_exact;
  req_t            req_major;
  req_t            req_minor;
  req_t            req_patch;
  longint unsigned fld [NUM_FIELDS];
  fidx_t           fidx;
  logic            digit_seen;
  logic            failed;
  verdict_t        verdict_q [$];
  int              mismatches;

  task automatic clear_parse();
    foreach (fld[i]) fld[i] = 0;
    fidx       = FIDX_MAJOR;
    digit_seen = 1'b0;
    failed     = 1'b0;
  endtask

  // Exact match, or caret: not below the requirement, bounded by its leftmost non-zero field.
  function automatic logic admits(longint unsigned ma, longint unsigned mi,
                                  longint unsigned pa);
    logic below;
    if (req_exact)
      return ma == req_major && mi == req_minor && pa == req_patch;
    if (ma != req_major)
      below = ma < req_major;
    else if (mi != req_minor)
      below = mi < req_minor;
    else
      below = pa < req_patch;
    if (below)
      return 1'b0;
    if (req_major != 0)
      return ma == req_major;
    if (req_minor != 0)
      return ma == 0 && mi == req_minor;
    if (req_patch != 0)
      return ma == 0 && mi == 0 && pa == req_patch;
    return ma == 0;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t        want;
    verdict_t        got;
    longint unsigned digit;
    if (!rst_n) begin
      req_exact = 1'b0;
      req_major = '0;
      req_minor = '0;
      req_patch = '0;
      clear_parse();
      verdict_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REQ_EXACT: req_exact = cfg_wdata[0];
          CFG_REQ_MAJOR: req_major = cfg_wdata;
          CFG_REQ_MINOR: req_minor = cfg_wdata;
          CFG_REQ_PATCH: req_patch = cfg_wdata;
          default: ;
        endcase
      end

      // results leave before this edge's item is counted, so the oldest one is compared
      if (out_valid && !out_stall) begin
        got = {out_well_formed, out_allowed, out_major, out_minor, out_patch};
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: wf=%0b ok=%0b %0d.%0d.%0d", $time,
                     got.well_formed, got.allowed, got.major, got.minor, got.patch);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected wf=%0b ok=%0b %0d.%0d.%0d,",
                        " got wf=%0b ok=%0b %0d.%0d.%0d"}, $time,
                       want.well_formed, want.allowed, want.major, want.minor, want.patch,
                       got.well_formed, got.allowed, got.major, got.minor, got.patch);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_has_char && !failed) begin
          if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
            digit = in_ch - CH_ZERO;
            if (fld[fidx] > (FIELD_MAX - digit) / 10) begin
              failed = 1'b1;
            end else begin
              fld[fidx]  = fld[fidx] * 10 + digit;
              digit_seen = 1'b1;
            end
          end else if (in_ch == CH_DOT) begin
            if (!digit_seen || fidx >= FIDX_PATCH) begin
              failed = 1'b1;
            end else begin
              fidx++;
              digit_seen = 1'b0;
            end
          end else begin
            failed = 1'b1;
          end
        end
        if (in_last) begin
          want = '0;
          if (!failed && digit_seen) begin
            want.well_formed = 1'b1;
            want.allowed     = admits(fld[0], fld[1], fld[2]);
            want.major       = fld[0][OUT_BITS-1:0];
            want.minor       = fld[1][OUT_BITS-1:0];
            want.patch       = fld[2][OUT_BITS-1:0];
          end
          verdict_q.push_back(want);
          clear_parse();
        end
      end
    end
    errors  <= mismatches;
    pending <= verdict_q.size();
  end

endmodule

// File: test/testbench.sv
// Testbench top: drives version strings and requirements into the block and gives the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vscm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_ITEMS   = 1250;
  localparam int CALM_ITEMS     = 1100;

  typedef struct {
    bit         has_char;
    logic [7:0] ch;
  } sym_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  req_t                cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_has_char;
  logic [7:0]          in_ch;
  logic                in_last;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_well_formed;
  logic                out_allowed;
  logic [OUT_BITS-1:0] out_major;
  logic [OUT_BITS-1:0] out_minor;
  logic [OUT_BITS-1:0] out_patch;
  int                  errors;
  int                  pending;

  sym_t            word_q [$];
  longint unsigned req_f [NUM_FIELDS];
  int              items_sent;
  int              idle_cycles;
  int              stall_run;
  bit              calm;
  bit              sender_gaps;

  version_string_caret_match i_dut (.*);
  vscm_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random runs of stall or free flow, each of random length
  always @(posedge clk) begin : out_idling
    bit hold;
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      hold = ($urandom_range(2) == 0);
      out_stall <= hold;
      stall_run <= hold ? $urandom_range(14) : $urandom_range(29);
    end
  end

  task automatic send_item(bit has_char, logic [7:0] ch, bit last);
    if (!calm && sender_gaps && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_has_char <= has_char;
    in_ch       <= ch;
    in_last     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has_char || last)
      items_sent++;
  endtask

  task automatic send_word();
    if (word_q.size() == 0)
      send_item(1'b0, 8'($urandom_range(255)), 1'b1);
    else
      foreach (word_q[i])
        send_item(word_q[i].has_char, word_q[i].ch, i == word_q.size() - 1);
    word_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      word_q.push_back('{1'b1, s[i]});
    send_word();
  endtask

  task automatic push_num(longint unsigned v, int zeros);
    logic [7:0] digits [$];
    repeat (zeros) word_q.push_back('{1'b1, CH_ZERO});
    do begin
      digits.push_front(8'(CH_ZERO + v % 10));
      v /= 10;
    end while (v != 0);
    foreach (digits[i])
      word_q.push_back('{1'b1, digits[i]});
  endtask

  // field values cluster round the requirement so that caret bounds are hit often
  function automatic longint unsigned pick_field(int f);
    case ($urandom_range(8))
      0, 1:    return $urandom_range(20);
      2:       return req_f[f];
      3:       return req_f[f] + 1;
      4:       return (req_f[f] == 0) ? 0 : req_f[f] - 1;
      5:       return 64'hFFFF_FFFF;
      6:       return $urandom;
      7:       return $urandom_range(999);
      default: return 64'h1_0000_0000 + $urandom_range(1000);
    endcase
  endfunction

  task automatic gen_word();
    int nf;
    int pos;
    nf = $urandom_range(3, 1);
    for (int f = 0; f < nf; f++) begin
      if (f != 0)
        word_q.push_back('{1'b1, CH_DOT});
      push_num(pick_field(f), ($urandom_range(5) == 0) ? $urandom_range(3, 1) : 0);
    end
    case ($urandom_range(9))
      0: begin
        pos = $urandom_range(word_q.size() - 1);
        word_q[pos].ch = 8'($urandom_range(255));
      end
      1: word_q.insert($urandom_range(word_q.size()), '{1'b1, CH_DOT});
      2: begin
        if ($urandom_range(1))
          word_q.delete();
        else
          void'(word_q.pop_back());
      end
      3: begin
        repeat ($urandom_range(3, 1))
          word_q.insert($urandom_range(word_q.size()), '{1'b0, 8'($urandom_range(255))});
      end
      default: ;
    endcase
  endtask

  // let every outstanding verdict drain, then allow for the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, req_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_requirement(bit exact, req_t ma, req_t mi, req_t pa);
    settle();
    write_reg(CFG_REQ_EXACT, req_t'(exact));
    write_reg(CFG_REQ_MAJOR, ma);
    write_reg(CFG_REQ_MINOR, mi);
    write_reg(CFG_REQ_PATCH, pa);
    cfg_we <= 1'b0;
    req_f[0] = ma;
    req_f[1] = mi;
    req_f[2] = pa;
  endtask

  initial begin
    string basic [$] = '{"0", "4294967295.4294967295.4294967295", "4294967296",
                         "00012.0.7", "1.", "", "1.2.3.", "1a9.9", ".5", "1..2",
                         "99999999999.1", "0.0"};
    int phase;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_REQ_EXACT;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_has_char <= 1'b0;
    in_ch       <= '0;
    in_last     <= 1'b0;
    calm        = 1'b0;
    sender_gaps = 1'b1;
    items_sent  = 0;
    foreach (req_f[i]) req_f[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset requirement is caret 0.0.0
    foreach (basic[i])
      send_text(basic[i]);
    // empty items inside a string and one ending it
    word_q.push_back('{1'b1, "3"});
    word_q.push_back('{1'b0, 8'hff});
    word_q.push_back('{1'b1, CH_DOT});
    word_q.push_back('{1'b1, "4"});
    word_q.push_back('{1'b0, 8'h00});
    send_word();

    set_requirement(1'b1, 1, 2, 3);
    send_text("1.2.3");
    send_text("1.2");
    set_requirement(1'b0, 1, 2, 3);
    send_text("1.9");
    send_text("1.2.2");
    send_text("2.0");
    set_requirement(1'b0, 0, 2, 3);
    send_text("0.2.5");
    send_text("0.3");
    set_requirement(1'b0, 0, 0, 3);
    send_text("0.0.3");
    send_text("0.0.4");

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase % 6)
        0: set_requirement(1'b0, 0, 0, 0);
        1: set_requirement(1'b0, $urandom_range(5, 1), $urandom, $urandom_range(20));
        2: set_requirement(1'b0, 0, $urandom_range(5, 1), $urandom_range(20));
        3: set_requirement(1'b0, 0, 0, $urandom_range(9, 1));
        4: set_requirement(1'b1, $urandom_range(3), $urandom_range(3), $urandom_range(3));
        default: set_requirement($urandom_range(1), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF);
      endcase
      sender_gaps = ($urandom_range(3) != 0);
      repeat (25) begin
        if (items_sent >= TARGET_ITEMS)
          break;
        calm = (items_sent >= CALM_ITEMS);
        gen_word();
        send_word();
      end
      phase++;
    end

    settle();
    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: version_string_caret_match.f
design/vscm_pkg.sv
design/version_string_caret_match.sv
test/vscm_checker.sv
test/testbench.sv
